### rtl/sprite_quad_vertex_rotator_defines.svh
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_ROTATOR_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_ROTATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SQVR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SQVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define SQVR_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sqvr_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator package
// Types, constants and the sine table shared by the rotator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sqvr_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;   // signed sin/cos
  localparam int PROD_W         = TRIG_FRAC_BITS + 25;  // 23 x TRIG_W product
  localparam int CTR_W          = TRIG_FRAC_BITS + 27;  // doubled centre, scaled
  localparam int SUM_W          = TRIG_FRAC_BITS + 29;  // corner accumulator

  localparam int ANGLE_STEPS = 360;
  localparam int ANGLE_BIAS  = 92 * ANGLE_STEPS;       // makes any 16-bit angle positive
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP_MULT  = (1 << RECIP_SHIFT) / ANGLE_STEPS + 1;

  localparam int OFIFO_DEPTH = 4;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [0:0] {
    REG_CAMERA_X = 1'b0,
    REG_CAMERA_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  // One quad after setup, as the corner generator needs it.
  typedef struct packed {
    logic signed [CTR_W-1:0]  cx;
    logic signed [CTR_W-1:0]  cy;
    logic signed [PROD_W-1:0] wc;
    logic signed [PROD_W-1:0] ws;
    logic signed [PROD_W-1:0] hc;
    logic signed [PROD_W-1:0] hs;
    logic [15:0]              u_left;
    logic [15:0]              u_right;
    logic [15:0]              v_top;
    logic [15:0]              v_bottom;
    logic [31:0]              rgba;
  } quad_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [31:0]        rgba;
    corner_t            corner;
    logic               last;
  } vertex_t;

  typedef logic [90:0][TRIG_FRAC_BITS:0] sin_tab_t;

  // Quarter-wave sine for 0..90 degrees, built at elaboration from a
  // truncated Taylor series in Q2.30 and rounded half up.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t           tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    for (int k = 0; k <= 90; k++) begin
      x    = (64'(k) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      rnd    = ($unsigned(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      tab[k] = rnd[TRIG_FRAC_BITS:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

### rtl/sqvr_front.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator front end
// Accepts quads, reduces the angle, looks up sin/cos and forms the
// per-quad products that the corner generator combines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqvr_front import sqvr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [23:0] camera_x,
  input  logic signed [23:0] camera_y,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [21:0]        quad_width,
  input  logic [21:0]        quad_height,
  input  logic signed [15:0] rotation_deg,
  input  logic               has_sprite,
  input  logic               flip_x,
  input  logic [15:0]        tex_left,
  input  logic [15:0]        tex_right,
  input  logic [15:0]        tex_top,
  input  logic [15:0]        tex_bottom,
  input  logic [31:0]        rgba,
  output logic               mq_push,
  output quad_t              mq_wdata,
  input  logic               mq_full
);

  // Stage 1 registers
  logic               s1_v;
  logic signed [24:0] s1_px;
  logic signed [24:0] s1_py;
  logic [21:0]        s1_w;
  logic [21:0]        s1_h;
  logic [16:0]        s1_ang;
  logic [7:0]         s1_q;
  logic [15:0]        s1_ul;
  logic [15:0]        s1_ur;
  logic [15:0]        s1_vt;
  logic [15:0]        s1_vb;
  logic [31:0]        s1_rgba;

  // Stage 2 registers
  logic                     s2_v;
  logic signed [26:0]       s2_cx2;
  logic signed [26:0]       s2_cy2;
  logic [21:0]              s2_w;
  logic [21:0]              s2_h;
  logic signed [TRIG_W-1:0] s2_sn;
  logic signed [TRIG_W-1:0] s2_cs;
  logic [15:0]              s2_ul;
  logic [15:0]              s2_ur;
  logic [15:0]              s2_vt;
  logic [15:0]              s2_vb;
  logic [31:0]              s2_rgba;

  logic        s1_ready;
  logic        s2_ready;
  logic [16:0] ang_ofs;
  logic [33:0] q_prod;
  logic [16:0] q_times;
  logic [8:0]  deg;
  logic [9:0]  deg_cos;
  logic [8:0]  deg_cos_w;
  logic [15:0] ul_sel;
  logic [15:0] ur_sel;

  function automatic logic signed [TRIG_W-1:0] sin_of(input logic [8:0] d);
    logic [6:0]               idx;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    if (d <= 9'd90) begin
      idx = d[6:0];
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 7'(9'd180 - d);
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - d);
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_TAB[idx]});
    return neg ? -mag : mag;
  endfunction

  assign s2_ready = !s2_v || !mq_full;
  assign s1_ready = !s1_v || s2_ready;
  assign full     = !s1_ready;
  assign mq_push  = s2_v && !mq_full;

  // Angle plus a multiple of 360 is always positive; the quotient comes
  // from a reciprocal multiply that is exact over this range.
  assign ang_ofs = 17'({{2{rotation_deg[15]}}, rotation_deg} + 18'(ANGLE_BIAS));
  assign q_prod  = 34'(ang_ofs) * 34'(RECIP_MULT);

  assign ul_sel = !has_sprite ? 16'd0 : (flip_x ? tex_right : tex_left);
  assign ur_sel = !has_sprite ? 16'd0 : (flip_x ? tex_left : tex_right);

  assign q_times   = 17'(s1_q) * 17'(ANGLE_STEPS);
  assign deg       = 9'(s1_ang - q_times);
  assign deg_cos   = 10'(deg) + 10'd90;
  assign deg_cos_w = (deg_cos >= 10'(ANGLE_STEPS)) ? 9'(deg_cos - 10'(ANGLE_STEPS))
                                                    : deg_cos[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= push;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && push) begin
      s1_px   <= 25'(pos_x) - 25'(camera_x);
      s1_py   <= 25'(pos_y) - 25'(camera_y);
      s1_w    <= quad_width;
      s1_h    <= quad_height;
      s1_ang  <= ang_ofs;
      s1_q    <= q_prod[RECIP_SHIFT+7:RECIP_SHIFT];
      s1_ul   <= ul_sel;
      s1_ur   <= ur_sel;
      s1_vt   <= has_sprite ? tex_top : 16'd0;
      s1_vb   <= has_sprite ? tex_bottom : 16'd0;
      s1_rgba <= rgba;
    end
    if (s2_ready && s1_v) begin
      s2_cx2  <= {s1_px[24], s1_px, 1'b0} + $signed({5'd0, s1_w});
      s2_cy2  <= {s1_py[24], s1_py, 1'b0} + $signed({5'd0, s1_h});
      s2_w    <= s1_w;
      s2_h    <= s1_h;
      s2_sn   <= sin_of(deg);
      s2_cs   <= sin_of(deg_cos_w);
      s2_ul   <= s1_ul;
      s2_ur   <= s1_ur;
      s2_vt   <= s1_vt;
      s2_vb   <= s1_vb;
      s2_rgba <= s1_rgba;
    end
  end

  // The four size-by-trig products are written straight into the queue.
  always_comb begin
    mq_wdata.cx       = {s2_cx2, {TRIG_FRAC_BITS{1'b0}}};
    mq_wdata.cy       = {s2_cy2, {TRIG_FRAC_BITS{1'b0}}};
    mq_wdata.wc       = $signed({1'b0, s2_w}) * s2_cs;
    mq_wdata.ws       = $signed({1'b0, s2_w}) * s2_sn;
    mq_wdata.hc       = $signed({1'b0, s2_h}) * s2_cs;
    mq_wdata.hs       = $signed({1'b0, s2_h}) * s2_sn;
    mq_wdata.u_left   = s2_ul;
    mq_wdata.u_right  = s2_ur;
    mq_wdata.v_top    = s2_vt;
    mq_wdata.v_bottom = s2_vb;
    mq_wdata.rgba     = s2_rgba;
  end

endmodule

### rtl/sqvr_quad_fifo.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator quad queue
// Two-entry queue of prepared quads between front end and corner generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqvr_quad_fifo import sqvr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  quad_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output quad_t rd_data,
  output logic  valid
);

  quad_t       entries [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

### rtl/sqvr_back.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator corner generator
// Steps through the four corners of the head quad, rounds and saturates the
// positions and holds finished vertices in a small output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sqvr_back import sqvr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    mq_valid,
  input  quad_t   mq_rdata,
  output logic    mq_pop,
  output logic    empty,
  input  logic    pop,
  output vertex_t out_word
);

  localparam int PTR_W = $clog2(OFIFO_DEPTH);
  localparam int CNT_W = $clog2(OFIFO_DEPTH + 2);

  corner_t                  k;
  logic                     issue;
  logic                     b1_v;
  logic signed [SUM_W-1:0]  b1_rx;
  logic signed [SUM_W-1:0]  b1_ry;
  logic [15:0]              b1_u;
  logic [15:0]              b1_vv;
  logic [31:0]              b1_rgba;
  corner_t                  b1_corner;

  logic signed [SUM_W-1:0]  cx_ext;
  logic signed [SUM_W-1:0]  cy_ext;
  logic signed [SUM_W-1:0]  wc_ext;
  logic signed [SUM_W-1:0]  ws_ext;
  logic signed [SUM_W-1:0]  hc_ext;
  logic signed [SUM_W-1:0]  hs_ext;

  vertex_t                  ofifo [OFIFO_DEPTH];
  logic [PTR_W-1:0]         wptr;
  logic [PTR_W-1:0]         rptr;
  logic [CNT_W-1:0]         ocount;
  logic                     opop;
  vertex_t                  vert;

  function automatic logic signed [23:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0]            t;
    logic signed [SUM_W-TRIG_FRAC_BITS-2:0] s;
    t = v + (SUM_W'(1) <<< TRIG_FRAC_BITS);
    s = t[SUM_W-1:TRIG_FRAC_BITS+1];
    if (s[$left(s):23] == {($left(s) - 22){s[23]}}) begin
      return s[23:0];
    end else if (s[$left(s)]) begin
      return 24'sh800000;
    end else begin
      return 24'sh7FFFFF;
    end
  endfunction

  assign cx_ext = {{(SUM_W - CTR_W){mq_rdata.cx[CTR_W-1]}}, mq_rdata.cx};
  assign cy_ext = {{(SUM_W - CTR_W){mq_rdata.cy[CTR_W-1]}}, mq_rdata.cy};
  assign wc_ext = {{(SUM_W - PROD_W){mq_rdata.wc[PROD_W-1]}}, mq_rdata.wc};
  assign ws_ext = {{(SUM_W - PROD_W){mq_rdata.ws[PROD_W-1]}}, mq_rdata.ws};
  assign hc_ext = {{(SUM_W - PROD_W){mq_rdata.hc[PROD_W-1]}}, mq_rdata.hc};
  assign hs_ext = {{(SUM_W - PROD_W){mq_rdata.hs[PROD_W-1]}}, mq_rdata.hs};

  // A corner is issued only when the output queue has room for it and for
  // the one already in the rounding stage.
  assign issue  = mq_valid && ((ocount + CNT_W'(b1_v)) < CNT_W'(OFIFO_DEPTH));
  assign mq_pop = issue && (k == CORNER_BR);
  assign opop   = pop && !empty;
  assign empty  = (ocount == '0);
  assign out_word = ofifo[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= CORNER_TL;
      b1_v <= 1'b0;
    end else begin
      b1_v <= issue;
      if (issue) begin
        k <= corner_t'(k + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_rx     <= cx_ext + (k[0] ? wc_ext : -wc_ext) - (k[1] ? hs_ext : -hs_ext);
      b1_ry     <= cy_ext + (k[0] ? ws_ext : -ws_ext) + (k[1] ? hc_ext : -hc_ext);
      b1_u      <= k[0] ? mq_rdata.u_right : mq_rdata.u_left;
      b1_vv     <= k[1] ? mq_rdata.v_bottom : mq_rdata.v_top;
      b1_rgba   <= mq_rdata.rgba;
      b1_corner <= k;
    end
  end

  always_comb begin
    vert.x      = round_sat(b1_rx);
    vert.y      = round_sat(b1_ry);
    vert.u      = b1_u;
    vert.v      = b1_vv;
    vert.rgba   = b1_rgba;
    vert.corner = b1_corner;
    vert.last   = (b1_corner == CORNER_BR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      ocount <= '0;
    end else begin
      if (b1_v) begin
        wptr <= PTR_W'(wptr + 1'b1);
      end
      if (opop) begin
        rptr <= PTR_W'(rptr + 1'b1);
      end
      ocount <= ocount + CNT_W'(b1_v) - CNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_v) begin
      ofifo[wptr] <= vert;
    end
  end

endmodule

### rtl/sprite_quad_vertex_rotator.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator
// Turns one sprite quad into four rotated, camera-relative vertices.
// Input side is a queue: drive the quad fields with push while full is low;
// the word is taken on that edge. Output side is a queue too: while empty is
// low the oldest vertex is on the vertex ports, and pop takes it. Vertices
// come out top-left, top-right, bottom-left, bottom-right; last marks the
// fourth. The camera registers are written through cfg_wr_en/cfg_addr/cfg_wdata
// (index 0 camera x, 1 camera y); the user must write them only while no quad is
// in flight, which the block does not enforce. Path: the first vertex of a quad
// passes the two front stages, the quad queue and the rounding register ahead of
// the vertex queue; the other three follow one per cycle while the vertex queue
// has room. The quad rate is set by the corner generator, which issues one vertex
// per cycle while a quad is waiting and the vertex queue has room; a quad can be
// accepted every cycle until the two front stages and the two-entry quad queue
// are full. Reset (synchronous, active high) clears the camera to zero and
// empties every stage and queue. When the receiver stops popping, the four-entry
// vertex queue fills, corner issue stops, then the quad queue and front stages
// fill and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sprite_quad_vertex_rotator_defines.svh"

module sprite_quad_vertex_rotator import sqvr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [0:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [21:0]        quad_width,
  input  logic [21:0]        quad_height,
  input  logic signed [15:0] rotation_deg,
  input  logic               has_sprite,
  input  logic               flip_x,
  input  logic [15:0]        tex_left,
  input  logic [15:0]        tex_right,
  input  logic [15:0]        tex_top,
  input  logic [15:0]        tex_bottom,
  input  logic [31:0]        rgba,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] vertex_x,
  output logic signed [23:0] vertex_y,
  output logic [15:0]        vertex_u,
  output logic [15:0]        vertex_v,
  output logic [31:0]        vertex_rgba,
  output logic [1:0]         corner,
  output logic               last
);

  // Camera registers; the user must write them only while the block is idle,
  // which the block itself does not enforce, so the front end reads them directly.
  logic signed [23:0] camera_x;
  logic signed [23:0] camera_y;

  logic    mq_push;
  logic    mq_full;
  logic    mq_pop;
  logic    mq_valid;
  quad_t   mq_wdata;
  quad_t   mq_rdata;
  vertex_t out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_CAMERA_X: camera_x <= cfg_wdata;
        REG_CAMERA_Y: camera_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: camera subtract, angle reduction, sin/cos lookup and the
  // four size-by-trig products, two register stages deep.
  sqvr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .camera_x     (camera_x),
    .camera_y     (camera_y),
    .push         (push),
    .full         (full),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .quad_width   (quad_width),
    .quad_height  (quad_height),
    .rotation_deg (rotation_deg),
    .has_sprite   (has_sprite),
    .flip_x       (flip_x),
    .tex_left     (tex_left),
    .tex_right    (tex_right),
    .tex_top      (tex_top),
    .tex_bottom   (tex_bottom),
    .rgba         (rgba),
    .mq_push      (mq_push),
    .mq_wdata     (mq_wdata),
    .mq_full      (mq_full)
  );

  // Decouples quad setup from corner generation.
  sqvr_quad_fifo u_quad_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mq_push),
    .wr_data (mq_wdata),
    .full    (mq_full),
    .rd_en   (mq_pop),
    .rd_data (mq_rdata),
    .valid   (mq_valid)
  );

  // Corner generator: one vertex per cycle unless stalled; four-word output queue.
  sqvr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .mq_valid (mq_valid),
    .mq_rdata (mq_rdata),
    .mq_pop   (mq_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  assign vertex_x    = out_word.x;
  assign vertex_y    = out_word.y;
  assign vertex_u    = out_word.u;
  assign vertex_v    = out_word.v;
  assign vertex_rgba = out_word.rgba;
  assign corner      = out_word.corner;
  assign last        = out_word.last;

  // A quad leaves the queue only when it holds one.
  `SQVR_ASSERT_IMPL(a_quad_pop_valid, mq_pop, mq_valid, "quad queue popped while empty")
  // The last flag marks the bottom-right corner and nothing else.
  `SQVR_ASSERT_IMPL(a_last_is_br, !empty, (last == (corner == CORNER_BR)), "last off corner")
  // The quad queue is never written while full.
  `SQVR_ASSERT_IMPL(a_quad_no_overflow, mq_push, !mq_full, "quad queue written while full")
  // Reset leaves both sides ready and nothing to deliver.
  `SQVR_ASSERT_ALWAYS_NEXT(a_reset_idle, rst, (empty && !full), "block not idle after reset")

endmodule

### tb/sv/quad_vertex_check_pkg.sv
// ----------------------------------------------------------------------------
// Quad vertex checking package
// Quad word type and a scoreboard that predicts the four rotated vertices
// of every accepted quad and compares them with the vertices that come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package quad_vertex_check_pkg;
  import sqvr_pkg::*;

  localparam int        TRIG_BITS    = 14;
  localparam longint    TRIG_ONE     = 64'sd1 <<< TRIG_BITS;
  localparam longint    SCREEN_MAX   = 64'sd8388607;
  localparam longint    SCREEN_MIN   = -64'sd8388608;
  localparam bit [63:0] PI_Q30_CONST = 64'd3373259426;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [21:0]        quad_width;
    logic [21:0]        quad_height;
    logic signed [15:0] rotation_deg;
    logic               has_sprite;
    logic               flip_x;
    logic [15:0]        tex_left;
    logic [15:0]        tex_right;
    logic [15:0]        tex_top;
    logic [15:0]        tex_bottom;
    logic [31:0]        rgba;
  } sprite_quad_t;

  class quad_vertex_scoreboard;
    longint  quarter_sine [0:90];
    longint  cam_x;
    longint  cam_y;
    vertex_t expected_vertices [$];
    int      fails;

    // The quarter-wave table is rebuilt here from the same truncated series
    // in Q2.30, then rounded half up to the trig fraction width.
    function new();
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      longint    sum;
      cam_x = 0;
      cam_y = 0;
      fails = 0;
      for (int k = 0; k <= 90; k++) begin
        x    = (64'(k) * PI_Q30_CONST) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        quarter_sine[k] = (sum + 64'sd32768) >>> 16;
      end
    endfunction

    function void set_camera(longint x, longint y);
      cam_x = x;
      cam_y = y;
    endfunction

    function longint sine_of(int deg);
      int a;
      a = deg % 360;
      if (a <= 90) begin
        return quarter_sine[a];
      end else if (a <= 180) begin
        return quarter_sine[180 - a];
      end else if (a <= 270) begin
        return -quarter_sine[a - 180];
      end
      return -quarter_sine[360 - a];
    endfunction

    // Drops the doubled scale and the trig fraction with round-half-up, then
    // clamps to the 24-bit screen range.
    function logic signed [23:0] to_screen(longint v);
      longint r;
      r = (v + TRIG_ONE) >>> (TRIG_BITS + 1);
      if (r > SCREEN_MAX) begin
        r = SCREEN_MAX;
      end else if (r < SCREEN_MIN) begin
        r = SCREEN_MIN;
      end
      return r[23:0];
    endfunction

    function void note_quad(sprite_quad_t q);
      longint      px;
      longint      py;
      longint      w;
      longint      h;
      longint      sn;
      longint      cs;
      longint      cx2;
      longint      cy2;
      longint      dx2;
      longint      dy2;
      int          deg;
      logic [15:0] u_l;
      logic [15:0] u_r;
      vertex_t     vx;
      px  = longint'(q.pos_x) - cam_x;
      py  = longint'(q.pos_y) - cam_y;
      w   = longint'(q.quad_width);
      h   = longint'(q.quad_height);
      deg = ((int'(q.rotation_deg) % 360) + 360) % 360;
      sn  = sine_of(deg);
      cs  = sine_of(deg + 90);
      cx2 = 2 * px + w;
      cy2 = 2 * py + h;
      u_l = q.flip_x ? q.tex_right : q.tex_left;
      u_r = q.flip_x ? q.tex_left : q.tex_right;
      for (int k = 0; k < 4; k++) begin
        dx2       = (k & 1) ? w : -w;
        dy2       = (k & 2) ? h : -h;
        vx.x      = to_screen(cx2 * TRIG_ONE + dx2 * cs - dy2 * sn);
        vx.y      = to_screen(cy2 * TRIG_ONE + dx2 * sn + dy2 * cs);
        vx.u      = q.has_sprite ? ((k & 1) ? u_r : u_l) : 16'd0;
        vx.v      = q.has_sprite ? ((k & 2) ? q.tex_bottom : q.tex_top) : 16'd0;
        vx.rgba   = q.rgba;
        vx.corner = corner_t'(k);
        vx.last   = (vx.corner == CORNER_BR);
        expected_vertices = {expected_vertices, vx};
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (expected_vertices.size() == 0) begin
        $error("vertex (%0d, %0d) corner %0d arrived with no quad waiting",
               got.x, got.y, got.corner);
        fails++;
        return;
      end
      want = expected_vertices.pop_front();
      compare_field("vertex_x", longint'(want.x), longint'(got.x));
      compare_field("vertex_y", longint'(want.y), longint'(got.y));
      compare_field("vertex_u", longint'(want.u), longint'(got.u));
      compare_field("vertex_v", longint'(want.v), longint'(got.v));
      compare_field("vertex_rgba", longint'(want.rgba), longint'(got.rgba));
      compare_field("corner", longint'(want.corner), longint'(got.corner));
      compare_field("last", longint'(want.last), longint'(got.last));
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

endpackage

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Sprite quad vertex rotator testbench
// Pushes directed and random quads under several camera settings, pops the
// rotated vertices with a varying stall pattern, and checks every vertex
// against a scoreboard prediction. Ends with a single verdict line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sqvr_pkg::*;
  import quad_vertex_check_pkg::*;

  // Roughly 700 vertices with slow popping fit in a small fraction of this.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int HOLD_CYCLES      = 250;
  localparam int RANDOM_PER_PHASE = 32;
  localparam int DRAIN_CYCLES     = 20;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [0:0]         cfg_addr;
  logic [23:0]        cfg_wdata;
  logic               push;
  logic               full;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [21:0]        quad_width;
  logic [21:0]        quad_height;
  logic signed [15:0] rotation_deg;
  logic               has_sprite;
  logic               flip_x;
  logic [15:0]        tex_left;
  logic [15:0]        tex_right;
  logic [15:0]        tex_top;
  logic [15:0]        tex_bottom;
  logic [31:0]        rgba;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [23:0] vertex_x;
  logic signed [23:0] vertex_y;
  logic [15:0]        vertex_u;
  logic [15:0]        vertex_v;
  logic [31:0]        vertex_rgba;
  logic [1:0]         corner;
  logic               last;

  quad_vertex_scoreboard sb;

  // Camera as last written, so random quads can be placed near the view.
  logic signed [23:0] cam_x_now;
  logic signed [23:0] cam_y_now;

  // The sender keeps its burst state across items.
  int burst_left;

  // Long hold-off requests: the main process bumps the count, the popping
  // process notices the change and stalls on its own cycle count.
  int hold_reqs;
  int hold_seen     = 0;
  int hold_left     = 0;
  int pop_mode      = 0;
  int pop_mode_left = 0;

  int      cycle_count = 0;
  vertex_t seen_vertex;

  sprite_quad_t directed_quads [$];

  sprite_quad_vertex_rotator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Vertex side. Handshake values are read at the edge before any update,
  // so pop and empty are exactly what the block saw on that edge. The next
  // pop value comes from a randomly chosen stall pattern held for a random
  // stretch, or from a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen_vertex.x      = vertex_x;
        seen_vertex.y      = vertex_y;
        seen_vertex.u      = vertex_u;
        seen_vertex.v      = vertex_v;
        seen_vertex.rgba   = vertex_rgba;
        seen_vertex.corner = corner_t'(corner);
        seen_vertex.last   = last;
        sb.check_vertex(seen_vertex);
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        if (pop_mode_left == 0) begin
          pop_mode      = $urandom_range(0, 3);
          pop_mode_left = $urandom_range(16, 96);
        end
        pop_mode_left = pop_mode_left - 1;
        case (pop_mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic sprite_quad_t quad_of(
      logic signed [23:0] px, logic signed [23:0] py,
      logic [21:0] w, logic [21:0] h, logic signed [15:0] rot,
      logic spr, logic flip, logic [15:0] ul, logic [15:0] ur,
      logic [15:0] vt, logic [15:0] vb, logic [31:0] col);
    sprite_quad_t q;
    q.pos_x        = px;
    q.pos_y        = py;
    q.quad_width   = w;
    q.quad_height  = h;
    q.rotation_deg = rot;
    q.has_sprite   = spr;
    q.flip_x       = flip;
    q.tex_left     = ul;
    q.tex_right    = ur;
    q.tex_top      = vt;
    q.tex_bottom   = vb;
    q.rgba         = col;
    return q;
  endfunction

  function automatic void add_directed(sprite_quad_t q);
    directed_quads = {directed_quads, q};
  endfunction

  // Texture coordinates stay in 0..1.0, with the two ends hit often.
  function automatic logic [15:0] random_uv();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd32768;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Most quads sit close to the camera with modest sizes so that the
  // rotated corners stay on screen; the rest use the full field ranges and
  // mostly end up saturated.
  function automatic sprite_quad_t random_quad();
    sprite_quad_t q;
    int           off;
    if ($urandom_range(0, 9) < 7) begin
      off           = int'($urandom_range(0, 131072)) - 65536;
      q.pos_x       = cam_x_now + off[23:0];
      off           = int'($urandom_range(0, 131072)) - 65536;
      q.pos_y       = cam_y_now + off[23:0];
      q.quad_width  = 22'($urandom_range(0, 65536));
      q.quad_height = 22'($urandom_range(0, 65536));
    end else begin
      q.pos_x       = 24'($urandom);
      q.pos_y       = 24'($urandom);
      q.quad_width  = 22'($urandom);
      q.quad_height = 22'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       q.rotation_deg = 16'($urandom_range(0, 359));
      1:       q.rotation_deg = 16'(-int'($urandom_range(1, 720)));
      2:       q.rotation_deg = 16'((int'($urandom_range(0, 8)) - 4) * 90);
      default: q.rotation_deg = 16'($urandom);
    endcase
    q.has_sprite = 1'($urandom_range(0, 1));
    q.flip_x     = 1'($urandom_range(0, 1));
    q.tex_left   = random_uv();
    q.tex_right  = random_uv();
    q.tex_top    = random_uv();
    q.tex_bottom = random_uv();
    q.rgba       = $urandom;
    return q;
  endfunction

  // Offers one quad word and returns on the edge that takes it. Called
  // right after a rising edge; push stays high if another word follows.
  task automatic send_quad(sprite_quad_t q);
    pos_x        <= q.pos_x;
    pos_y        <= q.pos_y;
    quad_width   <= q.quad_width;
    quad_height  <= q.quad_height;
    rotation_deg <= q.rotation_deg;
    has_sprite   <= q.has_sprite;
    flip_x       <= q.flip_x;
    tex_left     <= q.tex_left;
    tex_right    <= q.tex_right;
    tex_top      <= q.tex_top;
    tex_bottom   <= q.tex_bottom;
    rgba         <= q.rgba;
    push         <= 1'b1;
    do begin
      @(posedge clk);
    end while (full);
    sb.note_quad(q);
  endtask

  // Burst pacing: after a burst of random length the sender drops push for
  // a random gap. An eager sender never pauses.
  task automatic pace(bit eager);
    if (!eager) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
    end
  endtask

  // Stops sending and waits for every predicted vertex to be popped.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Camera writes happen only with nothing in flight; both registers are
  // written back to back with the enable held high across them.
  task automatic write_camera(logic signed [23:0] x, logic signed [23:0] y);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_CAMERA_X;
    cfg_wdata <= x;
    @(posedge clk);
    cfg_addr  <= REG_CAMERA_Y;
    cfg_wdata <= y;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cam_x_now = x;
    cam_y_now = y;
    sb.set_camera(x, y);
  endtask

  task automatic random_phase(logic signed [23:0] cx, logic signed [23:0] cy,
                              bit eager);
    wait_idle();
    write_camera(cx, cy);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      pace(eager);
      send_quad(random_quad());
    end
  endtask

  initial begin
    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_addr      = REG_CAMERA_X;
    cfg_wdata     = '0;
    push          = 1'b0;
    pos_x         = '0;
    pos_y         = '0;
    quad_width    = '0;
    quad_height   = '0;
    rotation_deg  = '0;
    has_sprite    = 1'b0;
    flip_x        = 1'b0;
    tex_left      = '0;
    tex_right     = '0;
    tex_top       = '0;
    tex_bottom    = '0;
    rgba          = '0;
    cam_x_now     = '0;
    cam_y_now     = '0;
    burst_left    = 0;
    hold_reqs     = 0;

    // Directed quads, run with the camera at its reset value of zero. They
    // cover the degenerate quad, texture flip with and without a sprite,
    // each quadrant and the wrap of negative and out-of-range angles, and
    // saturation of corners that land off the 24-bit screen range.
    add_directed(quad_of(24'sd0, 24'sd0, 22'd0, 22'd0, 16'sd0,
                         1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0));
    add_directed(quad_of(24'sd25728, 24'sd12800, 22'd16384, 22'd8192,
                         16'sd0, 1'b1, 1'b0, 16'd0, 16'd32768, 16'd0,
                         16'd32768, 32'hFFFFFFFF));
    add_directed(quad_of(24'sd25728, 24'sd12800, 22'd16384, 22'd8192,
                         16'sd0, 1'b1, 1'b1, 16'd4096, 16'd28672, 16'd1,
                         16'd32767, 32'h12345678));
    add_directed(quad_of(-24'sd300, 24'sd700, 22'd511, 22'd257, 16'sd30,
                         1'b0, 1'b1, 16'd32768, 16'd21845, 16'd32768,
                         16'd10922, 32'h80000001));
    add_directed(quad_of(24'sd1000, 24'sd2000, 22'd3000, 22'd1000, 16'sd90,
                         1'b1, 1'b0, 16'd100, 16'd200, 16'd300, 16'd400,
                         32'hA5A5A5A5));
    add_directed(quad_of(24'sd1000, 24'sd2000, 22'd3000, 22'd1000,
                         16'sd180, 1'b1, 1'b1, 16'd100, 16'd200, 16'd300,
                         16'd400, 32'h5A5A5A5A));
    add_directed(quad_of(24'sd1000, 24'sd2000, 22'd3000, 22'd1000,
                         16'sd270, 1'b1, 1'b0, 16'd32767, 16'd0, 16'd16384,
                         16'd16383, 32'h00FF00FF));
    add_directed(quad_of(-24'sd5000, -24'sd5000, 22'd2560, 22'd2560,
                         16'sd45, 1'b1, 1'b0, 16'd0, 16'd32768, 16'd0,
                         16'd32768, 32'hFF00FF00));
    add_directed(quad_of(24'sd77, -24'sd33, 22'd1001, 22'd999, 16'sd359,
                         1'b1, 1'b1, 16'd1, 16'd2, 16'd3, 16'd4,
                         32'h0F0F0F0F));
    add_directed(quad_of(24'sd77, -24'sd33, 22'd1001, 22'd999, 16'sd360,
                         1'b0, 1'b0, 16'd9, 16'd9, 16'd9, 16'd9,
                         32'hF0F0F0F0));
    add_directed(quad_of(24'sd4096, 24'sd4096, 22'd777, 22'd333, -16'sd1,
                         1'b1, 1'b0, 16'd1234, 16'd4321, 16'd2222,
                         16'd3333, 32'h01020304));
    add_directed(quad_of(24'sd4096, 24'sd4096, 22'd777, 22'd333, -16'sd90,
                         1'b1, 1'b1, 16'd1234, 16'd4321, 16'd2222,
                         16'd3333, 32'h05060708));
    add_directed(quad_of(24'sd4096, 24'sd4096, 22'd777, 22'd333,
                         -16'sd360, 1'b1, 1'b0, 16'd8, 16'd16, 16'd32,
                         16'd64, 32'h11111111));
    add_directed(quad_of(-24'sd8000, 24'sd8000, 22'd4000, 22'd6000,
                         -16'sd32768, 1'b1, 1'b0, 16'd32768, 16'd32768,
                         16'd32768, 16'd32768, 32'h22222222));
    add_directed(quad_of(24'sd8000, -24'sd8000, 22'd6000, 22'd4000,
                         16'sd32767, 1'b1, 1'b1, 16'd255, 16'd65280 >> 1,
                         16'd128, 16'd32640, 32'h44444444));
    add_directed(quad_of(24'sh7FFFFF, 24'sh7FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                         16'sd0, 1'b1, 1'b0, 16'd0, 16'd32768, 16'd0,
                         16'd32768, 32'h88888888));
    add_directed(quad_of(24'sh800000, 24'sh800000, 22'd0, 22'h3FFFFF,
                         16'sd180, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0,
                         32'hFFFF0000));
    add_directed(quad_of(24'sh7FFFFF, 24'sh800000, 22'h3FFFFF, 22'd0,
                         16'sd45, 1'b1, 1'b1, 16'd100, 16'd32000,
                         16'd50, 16'd31000, 32'h0000FFFF));
    add_directed(quad_of(24'sh800000, 24'sh7FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                         16'sd225, 1'b1, 1'b0, 16'd32768, 16'd0,
                         16'd32768, 16'd0, 32'hDEADBEEF));
    add_directed(quad_of(24'sd0, 24'sd0, 22'h3FFFFF, 22'h2AAAAA, 16'sd135,
                         1'b1, 1'b1, 16'd21845, 16'd10922, 16'd5461,
                         16'd27306, 32'h7FFFFFFE));
    add_directed(quad_of(24'sd1, -24'sd1, 22'd1, 22'd1, 16'sd315,
                         1'b1, 1'b0, 16'd32767, 16'd32767, 16'd32767,
                         16'd32767, 32'hC3C3C3C3));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_quads[i]) begin
      pace(1'b0);
      send_quad(directed_quads[i]);
    end

    // Random phases, each under its own camera setting, the register
    // extremes among them.
    random_phase(24'($urandom), 24'($urandom), 1'b0);

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so every queue fills and full rises.
    wait_idle();
    write_camera(24'sh7FFFFF, 24'sh7FFFFF);
    hold_reqs <= hold_reqs + 1;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_quad(random_quad());
    end

    random_phase(24'sh800000, 24'sh800000, 1'b0);
    random_phase(24'($urandom), 24'sd0, 1'b1);
    random_phase(24'sh7FFFFF, 24'sh800000, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
